FILE: rtl/bc_texture_block_decoder_core_macros.svh
// Assertion macros used by the back part of the texture block decoder.
`ifndef BC_TEXTURE_BLOCK_DECODER_CORE_MACROS_SVH
`define BC_TEXTURE_BLOCK_DECODER_CORE_MACROS_SVH

// The antecedent and the consequent hold in the same cycle.
`define BCTD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bctd assertion failed");

// The consequent holds in the cycle after the antecedent.
`define BCTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bctd assertion failed");

`endif

FILE: rtl/bctd_pkg.sv
// Package with types, constants and arithmetic helpers of the texture block decoder.
`timescale 1ns / 1ps

package bctd_pkg;

    localparam int HALF_W    = 64;
    localparam int BLOCK_W   = 12;
    localparam int PIXEL_W   = 14;
    localparam int SIDE_W    = 15;
    localparam int ARGB_W    = 32;
    localparam int TEXELS    = 16;
    localparam int TIDX_W    = 4;
    localparam int FMT_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 15;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Block format codes; code three decodes as DXT1.
    localparam logic [FMT_W-1:0] FMT_DXT1 = 2'd0;
    localparam logic [FMT_W-1:0] FMT_DXT3 = 2'd1;
    localparam logic [FMT_W-1:0] FMT_DXT5 = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Block after endpoint expansion and visibility check.
    typedef struct packed {
        logic [7:0]               r0;
        logic [7:0]               g0;
        logic [7:0]               b0;
        logic [7:0]               r1;
        logic [7:0]               g1;
        logic [7:0]               b1;
        logic                     three_mode;
        logic                     is_dxt3;
        logic                     is_dxt5;
        logic [2*TEXELS-1:0]      cidx;
        logic [HALF_W-1:0]        abits;
        logic [TEXELS-1:0]        mask;
        logic [BLOCK_W-1:0]       bx;
        logic [BLOCK_W-1:0]       by;
    } stage_t;

    // Block ready for texel emission, with both palettes built.
    typedef struct packed {
        logic [3:0][ARGB_W-1:0]   pal;
        logic [7:0][7:0]          apal;
        logic                     is_dxt3;
        logic                     is_dxt5;
        logic [2*TEXELS-1:0]      cidx;
        logic [HALF_W-1:0]        abits;
        logic [TEXELS-1:0]        mask;
        logic [BLOCK_W-1:0]       bx;
        logic [BLOCK_W-1:0]       by;
    } entry_t;

    // v*255/31 as v*8 + v*7/31, the second term by reciprocal multiplication.
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [7:0]  v7;
        logic [16:0] prod;
        v7   = 8'(v) * 8'd7;
        prod = 17'(v7) * 17'd265;
        return 8'({v, 3'b000}) + 8'(prod >> 13);
    endfunction

    // v*255/63 as v*4 + v/21.
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [11:0] prod;
        prod = 12'(v) * 12'd49;
        return 8'({v, 2'b00}) + 8'(prod >> 10);
    endfunction

    // Exact floor(x/3) for x up to 765.
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] prod;
        prod = 20'(x) * 20'd683;
        return 8'(prod >> 11);
    endfunction

    // Exact floor(x/7) for x up to 1785.
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] prod;
        prod = 23'(x) * 23'd2341;
        return 8'(prod >> 14);
    endfunction

    // Exact floor(x/5) for x up to 1275.
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [21:0] prod;
        prod = 22'(x) * 22'd1639;
        return 8'(prod >> 13);
    endfunction

endpackage

FILE: rtl/bctd_in_if.sv
// Interface of the compressed block channel.
`timescale 1ns / 1ps

interface bctd_in_if;
    import bctd_pkg::*;

    logic                valid;
    logic                ready;
    logic [HALF_W-1:0]   color_half;
    logic [HALF_W-1:0]   alpha_half;
    logic [BLOCK_W-1:0]  block_col;
    logic [BLOCK_W-1:0]  block_row;

    modport source (output valid, color_half, alpha_half, block_col, block_row, input ready);
    modport sink   (input valid, color_half, alpha_half, block_col, block_row, output ready);
endinterface

FILE: rtl/bctd_out_if.sv
// Interface of the decoded texel channel.
`timescale 1ns / 1ps

interface bctd_out_if;
    import bctd_pkg::*;

    logic                valid;
    logic                ready;
    logic [ARGB_W-1:0]   texel_argb;
    logic [PIXEL_W-1:0]  pixel_x;
    logic [PIXEL_W-1:0]  pixel_y;
    logic                last_texel;

    modport source (output valid, texel_argb, pixel_x, pixel_y, last_texel, input ready);
    modport sink   (input valid, texel_argb, pixel_x, pixel_y, last_texel, output ready);
endinterface

FILE: rtl/bctd_queue.sv
// Short queue of decoded blocks between the front and the back.
`timescale 1ns / 1ps

module bctd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bctd_pkg::entry_t  push_data,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output bctd_pkg::entry_t  head
);
    import bctd_pkg::*;

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + QPTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = pop  ? QPTR_W'(rd_ptr_reg + QPTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = QCNT_W'(count_reg + QCNT_W'(1));
        end
        else if (pop && !push)
        begin
            count_next = QCNT_W'(count_reg - QCNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

FILE: rtl/bctd_front.sv
// Front part: configuration, block intake, endpoint expansion and palette building.
`timescale 1ns / 1ps

module bctd_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    bctd_in_if.sink                               blk_in,
    input  logic                                  cfg_we,
    input  logic [bctd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [bctd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  q_full,
    output logic                                  push,
    output bctd_pkg::entry_t                      push_data
);
    import bctd_pkg::*;

    logic [FMT_W-1:0]   fmt_reg, fmt_next;
    logic [SIDE_W-1:0]  width_reg, width_next;
    logic [SIDE_W-1:0]  height_reg, height_next;

    logic               s1_valid_reg, s1_valid_next;
    stage_t             s1_reg, s1_next;

    logic               accept;
    logic               s1_drain;
    logic [15:0]        c0, c1;
    logic [3:0]         col_ok, row_ok;
    logic               is_dxt3, is_dxt5;

    logic [7:0]         a0, a1;
    logic [10:0]        asum;

    // Configuration writes.
    always_comb
    begin
        fmt_next    = fmt_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FORMAT: fmt_next    = cfg_wdata[FMT_W-1:0];
                CFG_WIDTH:  width_next  = cfg_wdata[SIDE_W-1:0];
                CFG_HEIGHT: height_next = cfg_wdata[SIDE_W-1:0];
                default:    ;
            endcase
        end
    end

    // A block with no visible texel leaves the stage without a queue slot.
    assign s1_drain     = s1_valid_reg && (!q_full || (s1_reg.mask == '0));
    assign push         = s1_valid_reg && (s1_reg.mask != '0) && !q_full;
    assign blk_in.ready = !s1_valid_reg || s1_drain;
    assign accept       = blk_in.valid && blk_in.ready;

    assign c0      = blk_in.color_half[15:0];
    assign c1      = blk_in.color_half[31:16];
    assign is_dxt3 = (fmt_reg == FMT_DXT3);
    assign is_dxt5 = (fmt_reg == FMT_DXT5);

    // Texel positions stay below the side limit, so comparing against the
    // raw size gives the same answer as comparing against the clamped one.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            col_ok[i] = ({1'b0, blk_in.block_col, 2'(i)} < width_reg);
            row_ok[i] = ({1'b0, blk_in.block_row, 2'(i)} < height_reg);
        end
    end

    always_comb
    begin
        s1_next            = s1_reg;
        s1_next.r0         = expand5(c0[15:11]);
        s1_next.g0         = expand6(c0[10:5]);
        s1_next.b0         = expand5(c0[4:0]);
        s1_next.r1         = expand5(c1[15:11]);
        s1_next.g1         = expand6(c1[10:5]);
        s1_next.b1         = expand5(c1[4:0]);
        s1_next.three_mode = !(is_dxt3 || is_dxt5) && (c0 <= c1);
        s1_next.is_dxt3    = is_dxt3;
        s1_next.is_dxt5    = is_dxt5;
        s1_next.cidx       = blk_in.color_half[63:32];
        s1_next.abits      = blk_in.alpha_half;
        s1_next.bx         = blk_in.block_col;
        s1_next.by         = blk_in.block_row;
        for (int t = 0; t < TEXELS; t++)
        begin
            s1_next.mask[t] = row_ok[t / 4] && col_ok[t % 4];
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_drain)
        begin
            s1_valid_next = 1'b0;
        end
    end

    assign a0 = s1_reg.abits[7:0];
    assign a1 = s1_reg.abits[15:8];

    // Palettes are built on the way into the queue.
    always_comb
    begin
        push_data         = '0;
        push_data.is_dxt3 = s1_reg.is_dxt3;
        push_data.is_dxt5 = s1_reg.is_dxt5;
        push_data.cidx    = s1_reg.cidx;
        push_data.abits   = s1_reg.abits;
        push_data.mask    = s1_reg.mask;
        push_data.bx      = s1_reg.bx;
        push_data.by      = s1_reg.by;

        push_data.pal[0] = {ALPHA_OPAQUE, s1_reg.r0, s1_reg.g0, s1_reg.b0};
        push_data.pal[1] = {ALPHA_OPAQUE, s1_reg.r1, s1_reg.g1, s1_reg.b1};
        if (s1_reg.three_mode)
        begin
            push_data.pal[2] = {ALPHA_OPAQUE,
                                8'((9'(s1_reg.r0) + 9'(s1_reg.r1)) >> 1),
                                8'((9'(s1_reg.g0) + 9'(s1_reg.g1)) >> 1),
                                8'((9'(s1_reg.b0) + 9'(s1_reg.b1)) >> 1)};
            push_data.pal[3] = '0;
        end
        else
        begin
            push_data.pal[2] = {ALPHA_OPAQUE,
                                div3({1'b0, s1_reg.r0, 1'b0} + 10'(s1_reg.r1)),
                                div3({1'b0, s1_reg.g0, 1'b0} + 10'(s1_reg.g1)),
                                div3({1'b0, s1_reg.b0, 1'b0} + 10'(s1_reg.b1))};
            push_data.pal[3] = {ALPHA_OPAQUE,
                                div3(10'(s1_reg.r0) + {1'b0, s1_reg.r1, 1'b0}),
                                div3(10'(s1_reg.g0) + {1'b0, s1_reg.g1, 1'b0}),
                                div3(10'(s1_reg.b0) + {1'b0, s1_reg.b1, 1'b0})};
        end

        push_data.apal[0] = a0;
        push_data.apal[1] = a1;
        for (int k = 0; k < 6; k++)
        begin
            if (a0 > a1)
            begin
                asum = 11'(6 - k) * 11'(a0) + 11'(k + 1) * 11'(a1);
                push_data.apal[2 + k] = div7(asum);
            end
            else if (k < 4)
            begin
                asum = 11'(4 - k) * 11'(a0) + 11'(k + 1) * 11'(a1);
                push_data.apal[2 + k] = div5(asum);
            end
            else
            begin
                asum = '0;
                push_data.apal[2 + k] = (k == 4) ? 8'h00 : 8'hFF;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg      <= FMT_DXT1;
            width_reg    <= SIDE_W'(4);
            height_reg   <= SIDE_W'(4);
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            fmt_reg      <= fmt_next;
            width_reg    <= width_next;
            height_reg   <= height_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end
endmodule

FILE: rtl/bctd_back.sv
// Back part: walks the visible texels of the head block, emitting one per cycle while texel_out is ready.
`timescale 1ns / 1ps
`include "bc_texture_block_decoder_core_macros.svh"

module bctd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  bctd_pkg::entry_t  q_head,
    output logic              q_pop,
    bctd_out_if.source        texel_out
);
    import bctd_pkg::*;

    logic [TEXELS-1:0]   done_reg, done_next;
    logic                out_valid_reg, out_valid_next;
    logic [ARGB_W-1:0]   argb_reg;
    logic [PIXEL_W-1:0]  px_reg;
    logic [PIXEL_W-1:0]  py_reg;
    logic                last_reg;

    logic [TEXELS-1:0]   rem;
    logic [TEXELS-1:0]   sel_bit;
    logic [TIDX_W-1:0]   sel;
    logic                load;
    logic                last_next;
    logic [1:0]          cidx;
    logic [2:0]          aidx;
    logic [3:0]          nib;
    logic [ARGB_W-1:0]   argb_next;

    assign rem = q_head.mask & ~done_reg;

    // Lowest texel still to be emitted.
    always_comb
    begin
        sel = '0;
        for (int i = TEXELS - 1; i >= 0; i--)
        begin
            if (rem[i])
            begin
                sel = TIDX_W'(i);
            end
        end
    end

    assign sel_bit   = TEXELS'(1) << sel;
    assign last_next = ((rem & ~sel_bit) == '0);
    assign load      = q_valid && (!out_valid_reg || texel_out.ready);
    assign q_pop     = load && last_next;

    assign cidx = q_head.cidx[2 * sel +: 2];
    assign aidx = q_head.abits[16 + 3 * sel +: 3];
    assign nib  = q_head.abits[4 * sel +: 4];

    always_comb
    begin
        argb_next = q_head.pal[cidx];
        if (q_head.is_dxt3)
        begin
            argb_next[31:24] = {nib, nib};
        end
        else if (q_head.is_dxt5)
        begin
            argb_next[31:24] = q_head.apal[aidx];
        end
    end

    always_comb
    begin
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            done_next      = last_next ? '0 : (done_reg | sel_bit);
            out_valid_next = 1'b1;
        end
        else if (texel_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            argb_reg <= argb_next;
            px_reg   <= {q_head.bx, sel[1:0]};
            py_reg   <= {q_head.by, sel[3:2]};
            last_reg <= last_next;
        end
    end

    assign texel_out.valid      = out_valid_reg;
    assign texel_out.texel_argb = argb_reg;
    assign texel_out.pixel_x    = px_reg;
    assign texel_out.pixel_y    = py_reg;
    assign texel_out.last_texel = last_reg;

    // A queued block always has a texel left to emit.
    `BCTD_ASSERT_NOW(a_head_has_work, q_valid, rem != '0)
    // The block leaves the queue only together with its last texel.
    `BCTD_ASSERT_NOW(a_pop_on_last, q_pop, load && last_next && q_valid)
    // After the last texel of a block the walk starts fresh.
    `BCTD_ASSERT_NEXT(a_walk_restart, load && last_next, done_reg == '0)
endmodule

FILE: rtl/bc_texture_block_decoder_core.sv
// Top level of the DXT1/DXT3/DXT5 texture block decoder.
//
//   Channel     Direction  Handshake          Carries
//   blk_in      in         valid/ready        color_half, alpha_half, block_col, block_row
//   texel_out   out        valid/ready        texel_argb, pixel_x, pixel_y, last_texel
//   cfg_*       in         write enable only  texture_format, image_width, image_height
//
// The first texel of a block passes the stage register, the queue and the output register.
// The output register emits one texel per cycle while texel_out is ready; a block has as
// many texels as are visible, sixteen inside the image, and hidden blocks emit none.
// A two-entry queue lets the front take blocks while the back stalls on texel_out.
// Reset sets the format to DXT1 and both image sides to four; no clearing pass.
`timescale 1ns / 1ps

module bc_texture_block_decoder_core (
    input  logic                             clk,
    input  logic                             rst_n,
    bctd_in_if.sink                          blk_in,
    bctd_out_if.source                       texel_out,
    input  logic                             cfg_we,
    input  logic [bctd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bctd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import bctd_pkg::*;

    logic    q_full;
    logic    q_push;
    logic    q_pop;
    logic    q_valid;
    entry_t  q_push_data;
    entry_t  q_head;

    bctd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk_in    (blk_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .push      (q_push),
        .push_data (q_push_data)
    );

    bctd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (q_head)
    );

    bctd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .texel_out (texel_out)
    );
endmodule

FILE: tb/bc_texture_block_decoder_core_tb.sv
// Self-checking testbench of the DXT1/DXT3/DXT5 texture block decoder.
`timescale 1ns / 1ps

module bc_texture_block_decoder_core_tb;
    import bctd_pkg::*;

    localparam int MAX_SIDE       = 16384;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 2000;

    // Format code three has no name of its own; it decodes as DXT1.
    localparam logic [FMT_W-1:0]     FMT_ALIAS_DXT1 = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED     = 2'd3;

    typedef struct {
        logic [HALF_W-1:0]  color_half;
        logic [HALF_W-1:0]  alpha_half;
        logic [BLOCK_W-1:0] block_col;
        logic [BLOCK_W-1:0] block_row;
        bit                 drain_first;
    } blk_t;

    typedef struct packed {
        logic [ARGB_W-1:0]  texel_argb;
        logic [PIXEL_W-1:0] pixel_x;
        logic [PIXEL_W-1:0] pixel_y;
        logic               last_texel;
    } texel_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    bctd_in_if  blk_ch();
    bctd_out_if texel_ch();

    bc_texture_block_decoder_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk_in    (blk_ch),
        .texel_out (texel_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    blk_t   pending_blocks[$];
    texel_t texel_expect_q[$];
    blk_t   shown_blk;
    texel_t want;
    int     errors;
    int     quiet_cycles;
    bit     no_idle;

    logic [FMT_W-1:0]      fmt_cfg;
    logic [CFG_DATA_W-1:0] width_cfg;
    logic [CFG_DATA_W-1:0] height_cfg;

    always #10 clk = ~clk;

    function automatic logic [31:0] opaque_rgb(input int r, input int g, input int b);
        return {8'hFF, 8'(r), 8'(g), 8'(b)};
    endfunction

    // Works out the visible texels of one block under the current register copy.
    task automatic predict_texels(input blk_t blk);
        logic [15:0] c0;
        logic [15:0] c1;
        logic [31:0] pal[4];
        logic [7:0]  apal[8];
        logic [31:0] argb;
        logic        three_mode;
        int          r0, g0, b0, r1, g1, b1, a0, a1, eff_w, eff_h, x, y;
        texel_t      tx;
        texel_t      found[$];
        c0 = blk.color_half[15:0];
        c1 = blk.color_half[31:16];
        r0 = int'(c0[15:11]) * 255 / 31;
        g0 = int'(c0[10:5]) * 255 / 63;
        b0 = int'(c0[4:0]) * 255 / 31;
        r1 = int'(c1[15:11]) * 255 / 31;
        g1 = int'(c1[10:5]) * 255 / 63;
        b1 = int'(c1[4:0]) * 255 / 31;
        pal[0] = opaque_rgb(r0, g0, b0);
        pal[1] = opaque_rgb(r1, g1, b1);
        three_mode = (fmt_cfg != FMT_DXT3) && (fmt_cfg != FMT_DXT5) && (c0 <= c1);
        if (!three_mode)
        begin
            pal[2] = opaque_rgb((2 * r0 + r1) / 3, (2 * g0 + g1) / 3, (2 * b0 + b1) / 3);
            pal[3] = opaque_rgb((r0 + 2 * r1) / 3, (g0 + 2 * g1) / 3, (b0 + 2 * b1) / 3);
        end
        else
        begin
            pal[2] = opaque_rgb((r0 + r1) / 2, (g0 + g1) / 2, (b0 + b1) / 2);
            pal[3] = 32'h0;
        end
        a0 = int'(blk.alpha_half[7:0]);
        a1 = int'(blk.alpha_half[15:8]);
        apal[0] = 8'(a0);
        apal[1] = 8'(a1);
        if (a0 > a1)
        begin
            for (int k = 0; k < 6; k++)
                apal[2 + k] = 8'(((6 - k) * a0 + (k + 1) * a1) / 7);
        end
        else
        begin
            for (int k = 0; k < 4; k++)
                apal[2 + k] = 8'(((4 - k) * a0 + (k + 1) * a1) / 5);
            apal[6] = 8'd0;
            apal[7] = 8'd255;
        end
        eff_w = (width_cfg > MAX_SIDE) ? MAX_SIDE : int'(width_cfg);
        eff_h = (height_cfg > MAX_SIDE) ? MAX_SIDE : int'(height_cfg);
        for (int t = 0; t < TEXELS; t++)
        begin
            x = int'(blk.block_col) * 4 + (t & 3);
            y = int'(blk.block_row) * 4 + (t >> 2);
            if (x < eff_w && y < eff_h)
            begin
                argb = pal[blk.color_half[32 + 2 * t +: 2]];
                if (fmt_cfg == FMT_DXT3)
                    argb[31:24] = 8'(int'(blk.alpha_half[4 * t +: 4]) * 17);
                else if (fmt_cfg == FMT_DXT5)
                    argb[31:24] = apal[blk.alpha_half[16 + 3 * t +: 3]];
                tx.texel_argb = argb;
                tx.pixel_x    = PIXEL_W'(x);
                tx.pixel_y    = PIXEL_W'(y);
                tx.last_texel = 1'b0;
                found.push_back(tx);
            end
        end
        if (found.size() != 0)
            found[found.size() - 1].last_texel = 1'b1;
        foreach (found[i])
            texel_expect_q.push_back(found[i]);
    endtask

    // Register copy, updated on the same edge as the block's registers.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            fmt_cfg    <= FMT_DXT1;
            width_cfg  <= 15'd4;
            height_cfg <= 15'd4;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FORMAT: fmt_cfg    <= cfg_wdata[FMT_W-1:0];
                CFG_WIDTH:  width_cfg  <= cfg_wdata;
                CFG_HEIGHT: height_cfg <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // Block driver. A block flagged drain_first waits until every texel has come.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            blk_ch.valid <= 1'b0;
        end
        else
        begin
            if (blk_ch.valid && blk_ch.ready)
                predict_texels(shown_blk);
            if (!blk_ch.valid || blk_ch.ready)
            begin
                if (pending_blocks.size() != 0
                    && !(pending_blocks[0].drain_first && texel_expect_q.size() != 0)
                    && (no_idle || $urandom_range(99) >= 33))
                begin
                    shown_blk = pending_blocks.pop_front();
                    blk_ch.valid      <= 1'b1;
                    blk_ch.color_half <= shown_blk.color_half;
                    blk_ch.alpha_half <= shown_blk.alpha_half;
                    blk_ch.block_col  <= shown_blk.block_col;
                    blk_ch.block_row  <= shown_blk.block_row;
                end
                else
                begin
                    blk_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Texel monitor with random back-pressure.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            texel_ch.ready <= 1'b0;
        end
        else
        begin
            if (texel_ch.valid && texel_ch.ready)
            begin
                if (texel_expect_q.size() == 0)
                begin
                    $error("unexpected texel at x=%0d y=%0d argb=%h",
                           texel_ch.pixel_x, texel_ch.pixel_y, texel_ch.texel_argb);
                    errors++;
                end
                else
                begin
                    want = texel_expect_q.pop_front();
                    if (texel_ch.texel_argb !== want.texel_argb)
                    begin
                        $error("texel_argb expected %h actual %h",
                               want.texel_argb, texel_ch.texel_argb);
                        errors++;
                    end
                    if (texel_ch.pixel_x !== want.pixel_x)
                    begin
                        $error("pixel_x expected %0d actual %0d", want.pixel_x, texel_ch.pixel_x);
                        errors++;
                    end
                    if (texel_ch.pixel_y !== want.pixel_y)
                    begin
                        $error("pixel_y expected %0d actual %0d", want.pixel_y, texel_ch.pixel_y);
                        errors++;
                    end
                    if (texel_ch.last_texel !== want.last_texel)
                    begin
                        $error("last_texel expected %0b actual %0b",
                               want.last_texel, texel_ch.last_texel);
                        errors++;
                    end
                end
            end
            texel_ch.ready <= no_idle || ($urandom_range(99) >= 33);
        end
    end

    // Ends the run when neither channel moves an item for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (blk_ch.valid && blk_ch.ready) || (texel_ch.valid && texel_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[bc_texture_block_decoder_core] ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Waits until every block is taken and decoded, hidden ones included.
    task automatic settle();
        do
            @(negedge clk);
        while (pending_blocks.size() != 0 || blk_ch.valid || texel_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_mode(input logic [FMT_W-1:0] fmt, input logic [CFG_DATA_W-1:0] w,
                            input logic [CFG_DATA_W-1:0] h);
        settle();
        write_reg(CFG_FORMAT, CFG_DATA_W'(fmt));
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        @(negedge clk);
    endtask

    task automatic add_block(input logic [HALF_W-1:0] chalf, input logic [HALF_W-1:0] ahalf,
                             input int col, input int row);
        blk_t b;
        b.color_half  = chalf;
        b.alpha_half  = ahalf;
        b.block_col   = BLOCK_W'(col);
        b.block_row   = BLOCK_W'(row);
        b.drain_first = 1'b0;
        pending_blocks.push_back(b);
    endtask

    // Mostly blocks that overlap the image, some anywhere in the block grid.
    function automatic logic [BLOCK_W-1:0] pick_block(input int side);
        int eff;
        int nblocks;
        eff = (side > MAX_SIDE) ? MAX_SIDE : side;
        nblocks = (eff + 3) / 4;
        if (nblocks == 0 || $urandom_range(99) < 15)
            return BLOCK_W'($urandom_range(4095));
        return BLOCK_W'($urandom_range(nblocks - 1));
    endfunction

    task automatic add_random(input int count, input int w, input int h, input int pause_at);
        blk_t b;
        for (int n = 0; n < count; n++)
        begin
            b.color_half = {$urandom, $urandom};
            if ($urandom_range(9) == 0)
                b.color_half[31:16] = b.color_half[15:0];
            b.alpha_half = {$urandom, $urandom};
            if ($urandom_range(9) == 0)
                b.alpha_half[15:8] = b.alpha_half[7:0];
            b.block_col   = pick_block(w);
            b.block_row   = pick_block(h);
            b.drain_first = (n == pause_at);
            pending_blocks.push_back(b);
        end
    endtask

    initial
    begin
        logic [47:0] ramp;
        clk               = 1'b0;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_FORMAT;
        cfg_wdata         = '0;
        blk_ch.valid      = 1'b0;
        blk_ch.color_half = '0;
        blk_ch.alpha_half = '0;
        blk_ch.block_col  = '0;
        blk_ch.block_row  = '0;
        texel_ch.ready    = 1'b0;
        errors            = 0;
        quiet_cycles      = 0;
        no_idle           = 1'b0;
        for (int t = 0; t < TEXELS; t++)
            ramp[3 * t +: 3] = 3'(t);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: DXT1 on a 4x4 image, then a block just right of it.
        add_block(64'hE4E4E4E4_0000FFFF, 64'h0, 0, 0);
        add_block(64'hE4E4E4E4_FFFF0000, 64'h0, 0, 0);
        add_block(64'hE4E4E4E4_0000FFFF, 64'h0, 1, 0);

        // DXT1 endpoints: equal, both modes, and the far corners of the grid.
        set_mode(FMT_DXT1, 15'd16384, 15'd16384);
        add_block(64'h0, 64'h0, 4095, 4095);
        add_block(64'hFFFFFFFF_FFFFFFFF, 64'h0, 0, 4095);
        add_block(64'h1B1B1B1B_7BEFF800, 64'h0, 4095, 0);
        add_block(64'h4E4E4E4E_001F07E0, 64'h0, 17, 3);
        add_block(64'h39C639C6_84108410, 64'h0, 2, 2);

        // DXT3: explicit alphas; c0 <= c1 stays in the four-colour mode.
        set_mode(FMT_DXT3, 15'd16384, 15'd16384);
        add_block(64'hE4E4E4E4_FFFF0000, 64'h0, 0, 0);
        add_block(64'h0, 64'hFFFFFFFF_FFFFFFFF, 1, 0);
        add_block(64'h5A5A5A5A_12345678, 64'hFEDCBA98_76543210, 5, 9);
        add_block(64'hFFFFFFFF_FFFFFFFF, 64'h01234567_89ABCDEF, 4095, 4095);

        // DXT5: eight-entry, six-entry and equal-endpoint alpha palettes.
        set_mode(FMT_DXT5, 15'd16384, 15'd16384);
        add_block(64'hE4E4E4E4_0000FFFF, {ramp, 8'h00, 8'hFF}, 0, 0);
        add_block(64'hE4E4E4E4_FFFF0000, {ramp, 8'hFF, 8'h00}, 1, 1);
        add_block(64'h1B1B1B1B_12344321, {ramp, 8'h80, 8'h80}, 2, 0);
        add_block(64'hA5A5A5A5_F00F0FF0, {~ramp, 8'h0D, 8'hC8}, 0, 3);

        // Format code three, and a write to an index with no register behind it.
        set_mode(FMT_ALIAS_DXT1, 15'd16384, 15'd16384);
        write_reg(CFG_UNUSED, 15'h7FFF);
        @(negedge clk);
        add_block(64'hE4E4E4E4_FFFF0000, 64'hFFFFFFFF_FFFFFFFF, 3, 3);

        // A zero width hides every texel; oversized sides saturate.
        set_mode(FMT_DXT1, 15'd0, 15'd16384);
        add_block(64'hE4E4E4E4_0000FFFF, 64'h0, 0, 0);
        add_block(64'hE4E4E4E4_0000FFFF, 64'h0, 4095, 4095);
        set_mode(FMT_DXT1, 15'd32767, 15'd32767);
        add_block(64'hE4E4E4E4_0000FFFF, 64'h0, 4095, 4095);

        // Partial blocks on the right and bottom edges.
        set_mode(FMT_DXT5, 15'd13, 15'd7);
        add_block(64'h1B1B1B1B_7BEFF800, {ramp, 8'h10, 8'hF0}, 3, 1);
        add_block(64'h4E4E4E4E_F8007BEF, {ramp, 8'hF0, 8'h10}, 0, 0);

        set_mode(FMT_DXT1, 15'd16384, 15'd16384);
        add_random(80, 16384, 16384, -1);
        set_mode(FMT_DXT3, 15'd37, 15'd22);
        add_random(70, 37, 22, -1);
        set_mode(FMT_DXT5, 15'd16384, 15'd1);
        add_random(60, 16384, 1, -1);
        set_mode(FMT_DXT5, 15'd4, 15'd4);
        no_idle = 1'b1;
        add_random(50, 4, 4, -1);
        settle();
        no_idle = 1'b0;
        set_mode(FMT_ALIAS_DXT1, 15'd1, 15'd16384);
        add_random(50, 1, 16384, -1);
        set_mode(FMT_DXT1, 15'd9, 15'd9);
        add_random(60, 9, 9, 30);
        set_mode(FMT_DXT5, 15'd16384, 15'd16384);
        add_random(100, 16384, 16384, 50);

        settle();
        if (texel_expect_q.size() != 0)
        begin
            $error("%0d expected texels never arrived", texel_expect_q.size());
            errors++;
        end
        if (errors == 0)
            $display("[bc_texture_block_decoder_core] OK");
        else
            $display("[bc_texture_block_decoder_core] ERROR");
        $finish;
    end

endmodule
